FILE: rtl/core/ultrasonic_echo_ranger_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the echo ranger checkers
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UER_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("echo ranger assertion failed");

// Next-cycle implication, disabled during reset.
`define UER_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("echo ranger assertion failed");

`endif

FILE: rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Configuration register indexes
  localparam logic CFG_WAIT_LIMIT = 1'b0;
  localparam logic CFG_WIDTH_CAP  = 1'b1;

  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd30000;
  localparam logic [12:0] WIDTH_CAP_RESET  = 13'd5000;

  localparam logic [3:0] PRE_LOW_TICKS = 4'd2;

  // distance_q8 = (width * 281) >> 6, about width * 0.01715 * 256
  localparam logic [8:0] DIST_MUL   = 9'd281;
  localparam int         DIST_SHIFT = 6;

  typedef struct packed {
    logic       start_req;
    logic [1:0] sensor_select;
    logic [2:0] echo_levels;
  } req_t;

  typedef struct packed {
    logic [2:0]  trigger_lines;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [13:0] echo_width_us;
    logic [15:0] distance_q8_cm;
  } rsp_t;

endpackage

FILE: rtl/core/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Drives ultrasonic trigger pulses and times the echo of one of three sensors.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per microsecond tick with start_req, sensor_select
//   and the echo pin levels. rsp channel: one beat per req beat, carrying the
//   trigger drive, busy/done flags and, on the done beat, status, echo width
//   and Q8 distance in cm.
//   Result path: the rsp beat of an accepted req beat is registered in the result
//   buffer and leaves it behind any earlier result still waiting there.
//   Throughput: one req beat per cycle while req_stall is low; the sequencer next
//   state and the 14x9 distance product are combinational ahead of the result register.
//   Stall: a two-entry result buffer holds results; req_stall rises only when
//   both entries are full, so one pending result never blocks the next tick.
//   Reset (rst, synchronous): sequencer idle, counters cleared, buffer empty,
//   echo_wait_limit = 30000, echo_width_cap = 5000.
//   Config: cfg_we/cfg_index/cfg_wdata; the user must write only while idle (not enforced).
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int NUM_SENSORS        = 3,
  parameter int TRIGGER_HIGH_TICKS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] echo_wait_limit;
  logic [12:0] echo_width_cap;
  logic        step;
  logic        full;
  rsp_t        core_rsp;

  assign req_stall = full;
  assign step      = req_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_wait_limit <= WAIT_LIMIT_RESET;
      echo_width_cap  <= WIDTH_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_LIMIT: echo_wait_limit <= cfg_wdata;
        CFG_WIDTH_CAP:  echo_width_cap  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  uer_core #(
    .NUM_SENSORS        (NUM_SENSORS),
    .TRIGGER_HIGH_TICKS (TRIGGER_HIGH_TICKS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .req             (req_data),
    .echo_wait_limit (echo_wait_limit),
    .echo_width_cap  (echo_width_cap),
    .rsp             (core_rsp)
  );

  uer_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (core_rsp),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: rtl/core/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core
// Trigger / wait / measure sequencer, advanced once per accepted tick beat.
// ----------------------------------------------------------------------------
module uer_core import uer_pkg::*; #(
  parameter int NUM_SENSORS        = 3,
  parameter int TRIGGER_HIGH_TICKS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  req_t        req,
  input  logic [15:0] echo_wait_limit,
  input  logic [12:0] echo_width_cap,
  output rsp_t        rsp
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PRELOW  = 3'd1;
  localparam logic [2:0] PH_HIGH    = 3'd2;
  localparam logic [2:0] PH_WAIT    = 3'd3;
  localparam logic [2:0] PH_MEASURE = 3'd4;

  localparam logic [2:0] NUM_SENSORS_C = 3'(NUM_SENSORS);
  localparam logic [3:0] HIGH_TICKS_C  = 4'(TRIGGER_HIGH_TICKS);

  logic [2:0]  phase, phase_next;
  logic [1:0]  active_sensor, active_sensor_next;
  logic [3:0]  pulse_counter, pulse_counter_next;
  logic [15:0] wait_counter, wait_counter_next;
  logic [13:0] width_counter, width_counter_next;

  logic        level;
  logic [3:0]  echo_ext;
  logic        done;
  logic        stat;
  logic [13:0] width_out;
  logic [3:0]  trig_full;
  logic [22:0] dist_prod;

  assign echo_ext = {1'b0, req.echo_levels};
  assign level    = echo_ext[active_sensor];

  always_comb begin
    phase_next         = phase;
    active_sensor_next = active_sensor;
    pulse_counter_next = pulse_counter;
    wait_counter_next  = wait_counter;
    width_counter_next = width_counter;
    done               = 1'b0;
    stat               = 1'b0;
    width_out          = '0;

    case (phase)
      PH_IDLE: begin
        if (req.start_req) begin
          if ({1'b0, req.sensor_select} < NUM_SENSORS_C) begin
            active_sensor_next = req.sensor_select;
            pulse_counter_next = 4'd1;
            phase_next         = PH_PRELOW;
          end else begin
            done = 1'b1;  // no sensor: empty result right away
          end
        end
      end
      PH_PRELOW: begin
        if (pulse_counter >= PRE_LOW_TICKS) begin
          phase_next         = PH_HIGH;
          pulse_counter_next = 4'd1;
        end else begin
          pulse_counter_next = pulse_counter + 4'd1;
        end
      end
      PH_HIGH: begin
        if (pulse_counter >= HIGH_TICKS_C) begin
          phase_next         = PH_WAIT;
          pulse_counter_next = '0;
          wait_counter_next  = '0;
        end else begin
          pulse_counter_next = pulse_counter + 4'd1;
        end
      end
      PH_WAIT: begin
        if (level) begin
          // rise tick counts as width 1
          phase_next         = PH_MEASURE;
          width_counter_next = 14'd1;
          if (echo_width_cap == '0) begin
            done      = 1'b1;
            width_out = 14'd1;
          end
        end else if (wait_counter >= echo_wait_limit) begin
          done = 1'b1;
          stat = 1'b1;
        end else begin
          wait_counter_next = wait_counter + 16'd1;
        end
      end
      PH_MEASURE: begin
        if (level) begin
          width_counter_next = width_counter + 14'd1;
          if (width_counter >= {1'b0, echo_width_cap}) begin
            done      = 1'b1;
            width_out = width_counter + 14'd1;
          end
        end else begin
          done      = 1'b1;
          width_out = width_counter;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (done) begin
      phase_next         = PH_IDLE;
      pulse_counter_next = '0;
      wait_counter_next  = '0;
      width_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      active_sensor <= '0;
      pulse_counter <= '0;
      wait_counter  <= '0;
      width_counter <= '0;
    end else if (step) begin
      phase         <= phase_next;
      active_sensor <= active_sensor_next;
      pulse_counter <= pulse_counter_next;
      wait_counter  <= wait_counter_next;
      width_counter <= width_counter_next;
    end
  end

  assign trig_full = 4'b0001 << active_sensor_next;
  assign dist_prod = 23'(width_out) * 23'(DIST_MUL);

  always_comb begin
    rsp.trigger_lines  = (phase_next == PH_HIGH) ? trig_full[2:0] : 3'b000;
    rsp.busy_res       = (phase_next != PH_IDLE);
    rsp.done_res       = done;
    rsp.status         = stat;
    rsp.echo_width_us  = width_out;
    rsp.distance_q8_cm = dist_prod[DIST_SHIFT +: 16];
  end

endmodule

FILE: rtl/core/uer_obuf.sv
// ----------------------------------------------------------------------------
// uer_obuf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module uer_obuf import uer_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t push_data,
  output logic full,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  logic [1:0] count;
  rsp_t       slot0;
  rsp_t       slot1;
  logic       pop;

  assign pop       = rsp_valid && !rsp_stall;
  assign rsp_valid = (count != 2'd0);
  assign rsp_data  = slot0;
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : push_data;
      if (count == 2'd2 && push) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

FILE: rtl/core/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the result channel of the echo ranger.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module uer_checker import uer_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_data
);

  // Measurement fields are only nonzero on a done beat
  `UER_ASSERT_IMP(a_quiet_unless_done, clk, rst, rsp_valid && !rsp_data.done_res, rsp_data.status == 1'b0 && rsp_data.echo_width_us == 14'd0 && rsp_data.distance_q8_cm == 16'd0)

  // A timeout carries no width
  `UER_ASSERT_IMP(a_timeout_zero, clk, rst, rsp_valid && rsp_data.done_res && rsp_data.status, rsp_data.echo_width_us == 14'd0 && rsp_data.distance_q8_cm == 16'd0)

  // Trigger drives one line at most, only while busy
  `UER_ASSERT_IMP(a_trigger_busy, clk, rst, rsp_valid && rsp_data.trigger_lines != 3'b000, $onehot(rsp_data.trigger_lines) && rsp_data.busy_res && !rsp_data.done_res)

  // A stalled result beat holds
  `UER_ASSERT_NXT(a_stall_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
